// ----- design/pli_pkg.sv -----
package pli_pkg;

    // fixed field widths
    localparam int DATA_W      = 16;
    localparam int INDEX_W     = 8;
    localparam int ROW_W       = 4;
    localparam int CHAN_CFG_W  = 4;
    localparam int POINT_CFG_W = 5;
    localparam int CFG_W       = 5;
    localparam int CFG_IDX_W   = 1;

    // default sizing
    localparam int DEF_CHANNELS     = 8;
    localparam int DEF_POINTS       = 16;
    localparam int DEF_MAX_ELEMENTS = 256;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTS   = 1'b1;

    // request codes
    localparam logic REQ_EVAL  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MOD,
        S_BASE,
        S_WRITE,
        S_SCAN,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_FIN
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ----- design/pli_if.sv -----
interface pli_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic [pli_pkg::INDEX_W-1:0]         element_index;
    logic [pli_pkg::ROW_W-1:0]           point_index;
    logic signed [pli_pkg::DATA_W-1:0]   x_value;
    logic signed [pli_pkg::DATA_W-1:0]   y_value;

    modport source (
        output valid, req_type, element_index, point_index, x_value, y_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, element_index, point_index, x_value, y_value,
        output ready
    );
endinterface

interface pli_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [pli_pkg::DATA_W-1:0]   y_out;
    logic [pli_pkg::INDEX_W-1:0]         out_index;

    modport source (
        output valid, y_out, out_index,
        input  ready
    );
    modport sink (
        input  valid, y_out, out_index,
        output ready
    );
endinterface

// ----- design/pli_div.sv -----
module pli_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [2*pli_pkg::DATA_W-1:0]       dividend,
    input  logic [pli_pkg::DATA_W-1:0]         divisor,
    output logic [pli_pkg::DATA_W-1:0]         quotient,
    output pli_pkg::div_status_t               status
);
    import pli_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    // restoring divider, one quotient bit per cycle; the high half of the
    // dividend must already be below the divisor
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] dq_reg;
    logic [DATA_W-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   diff;
    logic              ge;
    logic [DATA_W-1:0] rem_step;

    // one trial subtract
    always_comb
    begin
        trial    = {rem_reg, dq_reg[DATA_W-1]};
        diff     = trial - {1'b0, dvs_reg};
        ge       = (trial >= {1'b0, dvs_reg});
        rem_step = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '1;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // partial remainder and quotient shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[2*DATA_W-1:DATA_W];
            dq_reg  <= dividend[DATA_W-1:0];
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_step;
            dq_reg  <= {dq_reg[DATA_W-2:0], ge};
        end
    end

    assign quotient = dq_reg;
    assign status   = '{busy: busy_reg, done: done_reg};

endmodule

// ----- design/piecewise_linear_interpolator_top.sv -----
// Steps: a breakpoint write runs a serial channel remainder, forms the table base and
// writes one row. An evaluation runs the same remainder and base steps, reads one table
// row per cycle from the breakpoint memory (at most points_in_use, capped at POINTS, or
// one row when it is 0) and, when x interpolates, runs a multiply and a serial divider.
// Throughput: one item at a time; the next item is taken while the result waits.
// Reset: control and output valid clear, channels_in_use = 1, points_in_use = 2;
// breakpoint tables are not cleared and hold nothing defined until written.
module piecewise_linear_interpolator_top #(
    parameter int CHANNELS     = pli_pkg::DEF_CHANNELS,
    parameter int POINTS       = pli_pkg::DEF_POINTS,
    parameter int MAX_ELEMENTS = pli_pkg::DEF_MAX_ELEMENTS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    pli_req_if.sink                           req,
    pli_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [pli_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pli_pkg::CFG_W-1:0]         cfg_data
);
    import pli_pkg::*;

    localparam int DEPTH      = CHANNELS * POINTS;
    localparam int AW         = $clog2(DEPTH);
    localparam int MOD_CNT_W  = $clog2(INDEX_W);
    localparam int ELEM_CMP_W = ($clog2(MAX_ELEMENTS + 1) > INDEX_W) ?
                                $clog2(MAX_ELEMENTS + 1) : INDEX_W;
    localparam int PT_CMP_W   = ($clog2(POINTS + 1) > POINT_CFG_W) ?
                                $clog2(POINTS + 1) : POINT_CFG_W;
    localparam int CH_CMP_W   = ($clog2(CHANNELS + 1) > CHAN_CFG_W) ?
                                $clog2(CHANNELS + 1) : CHAN_CFG_W;

    // configuration
    logic [CHAN_CFG_W-1:0]  chan_cfg_reg;
    logic [POINT_CFG_W-1:0] point_cfg_reg;
    logic [CHAN_CFG_W-1:0]  eff_chan;
    logic [POINT_CFG_W-1:0] eff_pts;
    logic [POINT_CFG_W-1:0] last_row;

    // control
    state_t state_reg;
    state_t state_next;
    logic   req_acc;
    logic   item_ok;
    logic   mem_we;
    logic   div_start;
    logic   out_load;
    logic   issue_ok;
    logic   pend_reg;
    logic   out_valid_reg;

    // captured item
    logic                     req_type_reg;
    logic [INDEX_W-1:0]       elem_reg;
    logic [ROW_W-1:0]         row_reg;
    logic signed [DATA_W-1:0] x_reg;
    logic signed [DATA_W-1:0] yw_reg;

    // channel remainder
    logic [MOD_CNT_W-1:0]  mod_cnt_reg;
    logic [CHAN_CFG_W-1:0] mod_rem_reg;
    logic [CHAN_CFG_W:0]   mod_trial;
    logic [CHAN_CFG_W:0]   mod_diff;
    logic [CHAN_CFG_W-1:0] mod_rem_step;

    // breakpoint memories
    logic [DATA_W-1:0]        break_x_mem [DEPTH];
    logic [DATA_W-1:0]        break_y_mem [DEPTH];
    logic [AW-1:0]            base_reg;
    logic [AW-1:0]            mem_addr;
    logic signed [DATA_W-1:0] rd_x_reg;
    logic signed [DATA_W-1:0] rd_y_reg;

    // scan
    logic [POINT_CFG_W-1:0]   ir_reg;
    logic [POINT_CFG_W-1:0]   pend_row_reg;
    logic signed [DATA_W-1:0] prev_x_reg;
    logic signed [DATA_W-1:0] prev_y_reg;
    logic signed [DATA_W-1:0] yrun_reg;
    logic signed [DATA_W-1:0] res_reg;
    logic                     interp_reg;
    logic                     scan_fin;
    logic                     scan_hit;
    logic                     upd_prev;
    logic                     upd_run;
    logic                     scan_last;
    logic signed [DATA_W-1:0] scan_val;

    // interpolation
    logic signed [DATA_W-1:0]   y0_reg;
    logic signed [DATA_W:0]     dy_reg;
    logic [DATA_W-1:0]          dx_reg;
    logic [DATA_W-1:0]          dv_reg;
    logic signed [2*DATA_W+1:0] prod_reg;
    logic signed [2*DATA_W+1:0] prod_neg;
    logic [2*DATA_W-1:0]        div_dividend;
    logic [DATA_W-1:0]          div_quot;
    div_status_t                div_stat;
    logic [DATA_W-1:0]          q_adj;
    logic signed [DATA_W-1:0]   fin_y;

    // output stage
    logic signed [DATA_W-1:0] out_y_reg;
    logic [INDEX_W-1:0]       out_idx_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chan_cfg_reg  <= CHAN_CFG_W'(1);
            point_cfg_reg <= POINT_CFG_W'(2);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_CHANNELS: chan_cfg_reg  <= cfg_data[CHAN_CFG_W-1:0];
                CFG_POINTS:   point_cfg_reg <= cfg_data[POINT_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped channel and row counts
    always_comb
    begin
        if (chan_cfg_reg == '0)
            eff_chan = CHAN_CFG_W'(1);
        else if (CH_CMP_W'(chan_cfg_reg) > CH_CMP_W'(CHANNELS))
            eff_chan = CHAN_CFG_W'(CHANNELS);
        else
            eff_chan = chan_cfg_reg;

        if (PT_CMP_W'(point_cfg_reg) > PT_CMP_W'(POINTS))
            eff_pts = POINT_CFG_W'(POINTS);
        else
            eff_pts = point_cfg_reg;

        last_row = (eff_pts <= POINT_CFG_W'(1)) ? '0 : eff_pts - POINT_CFG_W'(1);
    end

    // request checks
    assign req_acc = req.valid && req.ready;
    assign item_ok = (ELEM_CMP_W'(req.element_index) < ELEM_CMP_W'(MAX_ELEMENTS)) &&
                     ((req.req_type == REQ_EVAL) ||
                      (PT_CMP_W'(req.point_index) < PT_CMP_W'(POINTS)));

    // one remainder bit per cycle
    always_comb
    begin
        mod_trial    = {mod_rem_reg, elem_reg[mod_cnt_reg]};
        mod_diff     = mod_trial - {1'b0, eff_chan};
        mod_rem_step = (mod_trial >= {1'b0, eff_chan}) ?
                       mod_diff[CHAN_CFG_W-1:0] : mod_trial[CHAN_CFG_W-1:0];
    end

    // scan decision on the row coming out of memory
    always_comb
    begin
        scan_fin  = 1'b0;
        scan_hit  = 1'b0;
        upd_prev  = 1'b0;
        upd_run   = 1'b0;
        scan_val  = yrun_reg;
        scan_last = (pend_row_reg == last_row);
        issue_ok  = (ir_reg <= last_row);
        if (state_reg == S_SCAN && pend_reg)
        begin
            if (pend_row_reg == '0)
            begin
                if (x_reg < rd_x_reg || scan_last)
                begin
                    scan_fin = 1'b1;
                    scan_val = rd_y_reg;
                end
                else
                begin
                    upd_prev = 1'b1;
                    upd_run  = 1'b1;
                end
            end
            else if (prev_x_reg == rd_x_reg)
            begin
                // degenerate pair
                upd_prev = 1'b1;
                scan_fin = scan_last;
            end
            else if (prev_x_reg <= x_reg && x_reg < rd_x_reg)
            begin
                scan_hit = 1'b1;
            end
            else
            begin
                upd_prev = 1'b1;
                upd_run  = 1'b1;
                if (scan_last)
                begin
                    scan_fin = 1'b1;
                    scan_val = rd_y_reg;
                end
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (req_acc && item_ok)
                    state_next = S_MOD;
            S_MOD:
                if (mod_cnt_reg == '0)
                    state_next = S_BASE;
            S_BASE:
                state_next = (req_type_reg == REQ_WRITE) ? S_WRITE : S_SCAN;
            S_WRITE:
                state_next = S_IDLE;
            S_SCAN:
                if (scan_fin)
                    state_next = S_FIN;
                else if (scan_hit)
                    state_next = S_MUL;
            S_MUL:
                state_next = S_DSTART;
            S_DSTART:
                state_next = S_DIV;
            S_DIV:
                if (div_stat.done)
                    state_next = S_FIN;
            S_FIN:
                if (out_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // state outputs
    always_comb
    begin
        req.ready = 1'b0;
        mem_we    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        mem_addr  = base_reg + AW'(ir_reg);
        case (state_reg)
            S_IDLE:   req.ready = 1'b1;
            S_WRITE:
            begin
                mem_we   = 1'b1;
                mem_addr = base_reg + AW'(row_reg);
            end
            S_DSTART: div_start = 1'b1;
            S_FIN:    out_load  = !out_valid_reg || rsp.ready;
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == S_SCAN) && issue_ok;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // breakpoint memories, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            break_x_mem[mem_addr] <= x_reg;
            break_y_mem[mem_addr] <= yw_reg;
        end
        rd_x_reg <= break_x_mem[mem_addr];
        rd_y_reg <= break_y_mem[mem_addr];
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (req_acc)
                begin
                    req_type_reg <= req.req_type;
                    elem_reg     <= req.element_index;
                    row_reg      <= req.point_index;
                    x_reg        <= req.x_value;
                    yw_reg       <= req.y_value;
                    mod_cnt_reg  <= '1;
                    mod_rem_reg  <= '0;
                end
            S_MOD:
            begin
                mod_rem_reg <= mod_rem_step;
                mod_cnt_reg <= mod_cnt_reg - MOD_CNT_W'(1);
            end
            S_BASE:
            begin
                base_reg <= AW'(mod_rem_reg) * AW'(POINTS);
                ir_reg   <= '0;
            end
            S_SCAN:
            begin
                if (issue_ok)
                    ir_reg <= ir_reg + POINT_CFG_W'(1);
                pend_row_reg <= ir_reg;
                if (upd_prev)
                begin
                    prev_x_reg <= rd_x_reg;
                    prev_y_reg <= rd_y_reg;
                end
                if (upd_run)
                    yrun_reg <= rd_y_reg;
                if (scan_fin)
                begin
                    res_reg    <= scan_val;
                    interp_reg <= 1'b0;
                end
                if (scan_hit)
                begin
                    interp_reg <= 1'b1;
                    y0_reg     <= prev_y_reg;
                    dy_reg     <= {rd_y_reg[DATA_W-1], rd_y_reg} -
                                  {prev_y_reg[DATA_W-1], prev_y_reg};
                    dx_reg     <= x_reg - prev_x_reg;
                    dv_reg     <= rd_x_reg - prev_x_reg;
                end
            end
            S_MUL:
                prod_reg <= (2*DATA_W+2)'(dy_reg) *
                            (2*DATA_W+2)'($signed({1'b0, dx_reg}));
            default: ;
        endcase
    end

    // magnitude of the product for the divider
    assign prod_neg     = -prod_reg;
    assign div_dividend = prod_reg[2*DATA_W+1] ? prod_neg[2*DATA_W-1:0] :
                                                 prod_reg[2*DATA_W-1:0];

    pli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (dv_reg),
        .quotient (div_quot),
        .status   (div_stat)
    );

    // quotient truncated toward zero, added to y0
    assign q_adj = prod_reg[2*DATA_W+1] ? (~div_quot + DATA_W'(1)) : div_quot;
    assign fin_y = interp_reg ? (y0_reg + $signed(q_adj)) : res_reg;

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_y_reg   <= fin_y;
            out_idx_reg <= elem_reg;
        end
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.y_out     = out_y_reg;
    assign rsp.out_index = out_idx_reg;

endmodule

// ----- verif/tb_piecewise_linear_interpolator_top.sv -----
module tb_piecewise_linear_interpolator_top;
    import pli_pkg::*;

    localparam int NCH         = DEF_CHANNELS;
    localparam int NPT         = DEF_POINTS;
    localparam int SETTLE      = 64;
    localparam int LONG_HOLD   = 400;
    localparam int MIX_ITEMS   = 55;
    localparam int NUM_PHASES  = 10;
    localparam int CH_SEQ [NUM_PHASES] = '{8, 0, 15, 3, 9, 2, 8, 5, 1, 7};
    localparam int PT_SEQ [NUM_PHASES] = '{16, 0, 31, 1, 17, 16, 2, 7, 2, 9};

    typedef logic signed [DATA_W-1:0] q88_t;

    typedef struct {
        logic              req_type;
        logic [INDEX_W-1:0] elem;
        logic [ROW_W-1:0]   row;
        q88_t              x;
        q88_t              y;
    } curve_req_t;

    typedef struct {
        q88_t               y;
        logic [INDEX_W-1:0] elem;
    } curve_rsp_t;

    // breakpoint tables, register copies and pending curve values
    class curve_scoreboard;
        q88_t         knot_x [NCH*NPT];
        q88_t         knot_y [NCH*NPT];
        int unsigned  chan_cfg  = 1;
        int unsigned  point_cfg = 2;
        curve_rsp_t   pending_vals [$];
        int           errors;
        int           n_writes;
        int           n_evals;
        int           n_checked;

        function int eff_chan();
            if (chan_cfg == 0)
                return 1;
            if (chan_cfg > NCH)
                return NCH;
            return chan_cfg;
        endfunction

        function int eff_points();
            if (point_cfg > NPT)
                return NPT;
            return point_cfg;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
            if (idx == CFG_CHANNELS)
                chan_cfg = v & 4'hF;
            else if (idx == CFG_POINTS)
                point_cfg = v & 5'h1F;
        endfunction

        // value of one curve at x
        function q88_t curve_value(int ch, int x);
            int     base;
            int     np;
            int     y;
            int     x0;
            int     x1;
            int     y0;
            int     y1;
            longint prod;
            base = ch * NPT;
            np   = eff_points();
            y    = int'(knot_y[base]);
            if (x < knot_x[base])
                return q88_t'(y);
            for (int j = 0; j + 1 < np; j++)
            begin
                x0 = int'(knot_x[base+j]);
                x1 = int'(knot_x[base+j+1]);
                if (x0 == x1)
                    continue;
                y0 = int'(knot_y[base+j]);
                y1 = int'(knot_y[base+j+1]);
                if (x0 <= x && x < x1)
                begin
                    prod = longint'(y1 - y0) * longint'(x - x0);
                    return q88_t'(longint'(y0) + prod / longint'(x1 - x0));
                end
                y = y1;
            end
            return q88_t'(y);
        endfunction

        function void note_request(curve_req_t r);
            int         ch;
            curve_rsp_t e;
            ch = r.elem % eff_chan();
            if (r.req_type == REQ_WRITE)
            begin
                knot_x[ch*NPT + r.row] = r.x;
                knot_y[ch*NPT + r.row] = r.y;
                n_writes++;
            end
            else
            begin
                e.y    = curve_value(ch, int'(r.x));
                e.elem = r.elem;
                pending_vals.push_back(e);
                n_evals++;
            end
        endfunction

        function void check_result(q88_t y, logic [INDEX_W-1:0] elem);
            curve_rsp_t e;
            if (pending_vals.size() == 0)
            begin
                $error("unexpected result: out_index %0d y_out %0d", elem, y);
                errors++;
                return;
            end
            e = pending_vals.pop_front();
            n_checked++;
            if (y !== e.y)
            begin
                $error("y_out mismatch: expected %0d, actual %0d", e.y, y);
                errors++;
            end
            if (elem !== e.elem)
            begin
                $error("out_index mismatch: expected %0d, actual %0d", e.elem, elem);
                errors++;
            end
        endfunction

        function int pending();
            return pending_vals.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    pli_req_if req_ch ();
    pli_rsp_if rsp_ch ();

    curve_scoreboard sb = new;

    int req_gap_max = 15;
    int rsp_gap_max = 15;
    bit rsp_hold_long;
    int n_cfg;

    piecewise_linear_interpolator_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #2000000;
        $display("tb_piecewise_linear_interpolator_top NOT OK");
        $finish;
    end

    // offer one request beat and note it once taken
    task automatic send(curve_req_t r);
        int gap;
        gap = $urandom_range(0, req_gap_max);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.req_type      <= r.req_type;
        req_ch.element_index <= r.elem;
        req_ch.point_index   <= r.row;
        req_ch.x_value       <= r.x;
        req_ch.y_value       <= r.y;
        req_ch.valid         <= 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic put(logic t, int elem, int row, int x, int y);
        curve_req_t r;
        r.req_type = t;
        r.elem     = INDEX_W'(elem);
        r.row      = ROW_W'(row);
        r.x        = q88_t'(x);
        r.y        = q88_t'(y);
        send(r);
    endtask

    // stop offering, let every result come back and the block go quiet
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(v);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        sb.set_reg(idx, v);
        n_cfg++;
    endtask

    // any element that lands on channel ch
    function automatic int elem_for(int ch);
        int ec;
        ec = sb.eff_chan();
        return ch + ec * $urandom_range(0, (255 - ch) / ec);
    endfunction

    function automatic int rows_read();
        return (sb.eff_points() < 1) ? 1 : sb.eff_points();
    endfunction

    // write a sorted curve into every row that an evaluation reads
    task automatic program_channel(int ch);
        int n;
        int lo;
        int span;
        int xs [$];
        n = rows_read();
        if ($urandom_range(0, 1))
        begin
            lo   = -32768;
            span = 65535;
        end
        else
        begin
            span = 32 * n * $urandom_range(1, 8);
            lo   = int'($urandom_range(0, 65535 - span)) - 32768;
        end
        for (int i = 0; i < n; i++)
            xs.push_back(lo + int'($urandom_range(0, span)));
        xs.sort();
        // occasional repeated x gives a zero-width segment
        for (int i = 1; i < n; i++)
            if ($urandom_range(0, 7) == 0)
                xs[i] = xs[i-1];
        for (int i = 0; i < n; i++)
            put(REQ_WRITE, elem_for(ch), i, xs[i], $urandom);
    endtask

    // x mostly inside the curve's span, sometimes on a breakpoint or anywhere
    function automatic int pick_x(int ch);
        int k;
        int first;
        int last;
        k     = $urandom_range(0, 9);
        first = int'(sb.knot_x[ch*NPT]);
        last  = int'(sb.knot_x[ch*NPT + rows_read() - 1]);
        if (k < 7 && last > first)
            return first + int'($urandom_range(0, last - first));
        if (k < 8)
            return int'(sb.knot_x[ch*NPT + $urandom_range(0, rows_read() - 1)]);
        return int'($urandom);
    endfunction

    // response side: random ready gaps, one long hold on request
    initial
    begin : rsp_side
        int gap;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = $urandom_range(0, rsp_gap_max);
            if (rsp_hold_long)
            begin
                gap           = LONG_HOLD;
                rsp_hold_long = 1'b0;
            end
            if (gap > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
            sb.check_result(rsp_ch.y_out, rsp_ch.out_index);
        end
    end

    // main stimulus
    initial
    begin : stimulus
        int ch;
        int k;
        curve_req_t r;
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_CHANNELS;
        cfg_data             = '0;
        req_ch.valid         = 1'b0;
        req_ch.req_type      = REQ_EVAL;
        req_ch.element_index = '0;
        req_ch.point_index   = '0;
        req_ch.x_value       = '0;
        req_ch.y_value       = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one channel, one segment
        put(REQ_WRITE, 0, 0, -256, 511);
        put(REQ_WRITE, 255, 1, 256, -512);
        put(REQ_EVAL, 0, 15, -32768, 0);
        put(REQ_EVAL, 1, 0, -256, 0);
        put(REQ_EVAL, 2, 0, -255, 0);
        put(REQ_EVAL, 3, 0, 0, 0);
        put(REQ_EVAL, 4, 0, 255, 0);
        put(REQ_EVAL, 5, 0, 256, 0);
        put(REQ_EVAL, 255, 0, 32767, -1);
        // widest segment, largest product
        put(REQ_WRITE, 7, 0, -32768, 32767);
        put(REQ_WRITE, 9, 1, 32767, -32768);
        put(REQ_WRITE, 11, 15, -1, -1);
        put(REQ_EVAL, 10, 0, -32768, 0);
        put(REQ_EVAL, 12, 0, 1, 0);
        put(REQ_EVAL, 13, 0, 32766, 0);

        // four rows with a zero-width first segment
        wait_drained();
        write_reg(CFG_POINTS, 4);
        put(REQ_WRITE, 0, 0, 0, 100);
        put(REQ_WRITE, 0, 1, 0, 200);
        put(REQ_WRITE, 0, 2, 512, 300);
        put(REQ_WRITE, 0, 3, 1024, -400);
        put(REQ_EVAL, 20, 0, -1, 0);
        put(REQ_EVAL, 21, 0, 0, 0);
        put(REQ_EVAL, 22, 0, 700, 0);
        put(REQ_EVAL, 23, 0, 2000, 0);

        // only a zero-width pair searched
        wait_drained();
        write_reg(CFG_POINTS, 2);
        put(REQ_EVAL, 24, 0, 5, 0);

        // random phases over a range of settings
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            req_gap_max = (p % 3 == 1) ? 0 : 15;
            rsp_gap_max = (p % 4 == 2) ? 0 : 15;
            write_reg(CFG_CHANNELS, CH_SEQ[p]);
            write_reg(CFG_POINTS, PT_SEQ[p]);
            for (int c = 0; c < sb.eff_chan(); c++)
                program_channel(c);
            if (p == 0)
                rsp_hold_long = 1'b1;
            for (int i = 0; i < MIX_ITEMS; i++)
            begin
                k  = $urandom_range(0, 19);
                ch = $urandom_range(0, sb.eff_chan() - 1);
                if (k == 0)
                    program_channel(ch);
                else if (k < 3)
                begin
                    // stray write anywhere, may break the ordering
                    r.req_type = REQ_WRITE;
                    r.elem     = INDEX_W'($urandom);
                    r.row      = ROW_W'($urandom);
                    r.x        = q88_t'($urandom);
                    r.y        = q88_t'($urandom);
                    send(r);
                end
                else
                begin
                    r.req_type = REQ_EVAL;
                    r.elem     = INDEX_W'(elem_for(ch));
                    r.row      = ROW_W'($urandom);
                    r.x        = q88_t'(pick_x(ch));
                    r.y        = q88_t'($urandom);
                    send(r);
                end
            end
        end

        wait_drained();
        $display("covered %0d breakpoint writes and %0d evaluations (%0d results checked)",
                 sb.n_writes, sb.n_evals, sb.n_checked);
        $display("over %0d register writes, with channel and row counts at and past their limits",
                 n_cfg);
        if (sb.errors == 0)
            $display("tb_piecewise_linear_interpolator_top OK");
        else
            $display("tb_piecewise_linear_interpolator_top NOT OK");
        $finish;
    end

endmodule

// ----- piecewise_linear_interpolator_top.f -----
design/pli_pkg.sv
design/pli_if.sv
design/pli_div.sv
design/piecewise_linear_interpolator_top.sv
verif/tb_piecewise_linear_interpolator_top.sv
